// File: rtl/pwn_pkg.sv
package pwn_pkg;

    // Frame store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int COEF_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int N_COEF     = 9;
    localparam int CIDX_W     = $clog2(N_COEF);

    // Shared multiplier: signed coefficient times signed small operand
    localparam int MB_W      = SIZE_W + 1;
    localparam int PROD_W    = COEF_W + MB_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int NUM_W     = ACC_W + 2;
    localparam int STEP_W    = 3;
    localparam int MUL_LAST  = 6;

    // Divider: enough quotient bits to tell any in-frame coordinate from overflow
    localparam int QB        = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DIV_W     = NUM_W + QB;
    localparam int CNT_W     = $clog2(QB + 1);

    localparam logic [COEF_W-1:0] Q20_ONE = COEF_W'(1048576);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_AB,
        CFG_ROW0C_ROW1A,
        CFG_ROW1_BC,
        CFG_ROW2_AB,
        CFG_ROW2_C,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DPREP,
        S_DSTART,
        S_DITER,
        S_ADDR,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [7:0]       out_col;
        logic [7:0]       out_row;
        logic             outside;
        logic             last_pixel;
    } t_out;

endpackage

// File: rtl/perspective_warp_nearest.sv
// Nearest-neighbor perspective warp of an 8-bit grayscale frame. A load transaction
// (action 0) writes the next source pixel in raster order; an emit transaction
// (action 1) returns the next output pixel in raster order, found by mapping
// (x, y, 1) through the inverse matrix and rounding u/w and v/w to the nearest
// integer (ties toward +inf per trunc(q+0.5)). An emit uses the single 32x10
// multiplier (six products plus the row offset) and the restoring divider that
// retires one quotient bit per cycle, nine bits for each of the two coordinates;
// both divisions are skipped when w is zero, but the second still runs when the
// first coordinate already falls outside. o_in_stall stays high while an emit is
// in progress and in the cycle after each configuration write. Source points
// outside the frame, or w equal to zero, give pixel 0 with outside set. Load the
// full frame before emitting.
module perspective_warp_nearest (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pwn_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pwn_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwn_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pwn_pkg::*;

    // Control state
    t_state                  r_state, n_state;
    logic                    r_out_valid;
    logic                    r_settle;
    logic [ADDR_W-1:0]       r_load_pos;
    logic [ADDR_W:0]         r_size;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [COEF_W-1:0]       r_coef [N_COEF];
    logic [SIZE_W-1:0]       r_eff_w, r_eff_h;

    // Datapath
    logic [COL_W-1:0]        r_cur_col;
    logic [ROW_W-1:0]        r_cur_row;
    logic                    r_last;
    logic [STEP_W-1:0]       r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_u, r_acc_v, r_acc_w;
    logic                    r_axis;
    logic signed [NUM_W-1:0] r_num, r_den;
    logic                    r_neg;
    logic [DIV_W-1:0]        r_rem, r_dsh;
    logic [QB:0]             r_quo;
    logic [CNT_W-1:0]        r_bitcnt;
    logic [QB-1:0]           r_sx, r_sy;
    logic                    r_outside;
    logic [PIX_W-1:0]        r_rd;
    t_out                    r_out;

    logic [PIX_W-1:0]        r_mem [STORE_SIZE];

    // Combinational helpers
    logic                    n_in_acc, n_out_acc, n_cfg_acc, n_load, n_emit, n_finish;
    logic [ADDR_W:0]         n_pos, n_pos_inc;
    logic [COL_W-1:0]        n_col_cur;
    logic [ROW_W-1:0]        n_row_cur;
    logic [SIZE_W-1:0]       n_col_inc, n_row_inc;
    logic [2*SIZE_W-1:0]     n_size_full;
    logic [CIDX_W-1:0]       n_cidx;
    logic signed [COEF_W-1:0] n_ma;
    logic signed [MB_W-1:0]  n_mb;
    logic signed [ACC_W-1:0] n_sel;
    logic signed [NUM_W-1:0] n_num, n_den;
    logic [NUM_W-1:0]        n_num_mag, n_den_mag;
    logic                    n_ge;
    logic [QB:0]             n_quo;
    logic [SIZE_W-1:0]       n_lim;
    logic                    n_ok;
    logic [ADDR_W-1:0]       n_addr;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] vmax);
        logic [SIZE_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = SIZE_W'(1);
        end
        if (r > vmax) begin
            r = vmax;
        end
        return r;
    endfunction

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE) || r_settle;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign n_in_acc    = i_in_valid && !o_in_stall;
    assign n_out_acc   = r_out_valid && !i_out_stall;
    assign n_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign n_load      = n_in_acc && (i_in_data.action == ACT_LOAD);
    assign n_emit      = n_in_acc && (i_in_data.action == ACT_EMIT);
    assign n_finish    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Load position with wrap, and emit position with wrap
    always_comb begin
        n_pos       = (ADDR_W+1)'(r_load_pos) < r_size ? (ADDR_W+1)'(r_load_pos) : '0;
        n_pos_inc   = n_pos + 1'b1;
        n_col_cur   = (SIZE_W'(r_col) >= r_eff_w) ? '0 : r_col;
        n_row_cur   = (SIZE_W'(r_row) >= r_eff_h) ? '0 : r_row;
        n_col_inc   = SIZE_W'(n_col_cur) + 1'b1;
        n_row_inc   = SIZE_W'(n_row_cur) + 1'b1;
        n_size_full = r_eff_w * r_eff_h;
    end

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_step)
            3'd0:    n_cidx = CIDX_W'(0);
            3'd1:    n_cidx = CIDX_W'(1);
            3'd2:    n_cidx = CIDX_W'(3);
            3'd3:    n_cidx = CIDX_W'(4);
            3'd4:    n_cidx = CIDX_W'(6);
            3'd5:    n_cidx = CIDX_W'(7);
            default: n_cidx = CIDX_W'(0);
        endcase
        if (r_state == S_ADDR) begin
            n_ma = signed'(COEF_W'(r_sy));
            n_mb = signed'(MB_W'(r_eff_w));
        end else begin
            n_ma = signed'(r_coef[n_cidx]);
            n_mb = r_step[0] ? signed'(MB_W'(r_cur_row)) : signed'(MB_W'(r_cur_col));
        end
    end

    // Divider operands and one restoring step
    always_comb begin
        n_sel     = r_axis ? r_acc_v : r_acc_u;
        n_num     = (NUM_W'(n_sel) <<< 1) + NUM_W'(r_acc_w);
        n_den     = NUM_W'(r_acc_w) <<< 1;
        n_num_mag = r_num[NUM_W-1] ? unsigned'(-r_num) : unsigned'(r_num);
        n_den_mag = r_den[NUM_W-1] ? unsigned'(-r_den) : unsigned'(r_den);
        n_ge      = (r_rem >= r_dsh);
        n_quo     = {r_quo[QB-1:0], n_ge};
        n_lim     = r_axis ? r_eff_h : r_eff_w;
        n_ok      = !n_quo[QB] && (!r_neg || (n_quo == '0))
                    && (SIZE_W'(n_quo[QB-1:0]) < n_lim);
        n_addr    = ADDR_W'(r_prod) + ADDR_W'(r_sx);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (n_emit) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_step == STEP_W'(MUL_LAST)) begin
                    n_state = S_DPREP;
                end
            end
            S_DPREP: begin
                n_state = (r_acc_w == '0) ? S_DONE : S_DSTART;
            end
            S_DSTART: begin
                n_state = S_DITER;
            end
            S_DITER: begin
                if (r_bitcnt == CNT_W'(QB)) begin
                    if (!r_axis) begin
                        n_state = S_DPREP;
                    end else if (r_outside || !n_ok) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (n_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers, configuration and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_settle    <= 1'b0;
            r_load_pos  <= '0;
            r_size      <= (ADDR_W+1)'(STORE_SIZE);
            r_col       <= '0;
            r_row       <= '0;
            r_eff_w     <= SIZE_W'(MAX_WIDTH);
            r_eff_h     <= SIZE_W'(MAX_HEIGHT);
            for (int i = 0; i < N_COEF; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[0]   <= Q20_ONE;
            r_coef[4]   <= Q20_ONE;
            r_coef[8]   <= Q20_ONE;
        end else begin
            r_size   <= n_size_full[ADDR_W:0];
            r_settle <= n_cfg_acc;

            // Hold the result until the consumer takes it
            if (n_finish) begin
                r_out_valid <= 1'b1;
            end else if (n_out_acc) begin
                r_out_valid <= 1'b0;
            end

            // Advance load position
            if (n_load) begin
                r_load_pos <= (n_pos_inc >= r_size) ? '0 : n_pos_inc[ADDR_W-1:0];
            end

            // Advance emit position
            if (n_emit) begin
                if (n_col_inc >= r_eff_w) begin
                    r_col <= '0;
                    r_row <= (n_row_inc >= r_eff_h) ? '0 : n_row_inc[ROW_W-1:0];
                end else begin
                    r_col <= n_col_inc[COL_W-1:0];
                    r_row <= n_row_cur;
                end
            end

            if (n_cfg_acc) begin
                case (i_cfg_index)
                    CFG_ROW0_AB: begin
                        r_coef[0] <= i_cfg_data[31:0];
                        r_coef[1] <= i_cfg_data[63:32];
                    end
                    CFG_ROW0C_ROW1A: begin
                        r_coef[2] <= i_cfg_data[31:0];
                        r_coef[3] <= i_cfg_data[63:32];
                    end
                    CFG_ROW1_BC: begin
                        r_coef[4] <= i_cfg_data[31:0];
                        r_coef[5] <= i_cfg_data[63:32];
                    end
                    CFG_ROW2_AB: begin
                        r_coef[6] <= i_cfg_data[31:0];
                        r_coef[7] <= i_cfg_data[63:32];
                    end
                    CFG_ROW2_C: begin
                        r_coef[8] <= i_cfg_data[31:0];
                    end
                    CFG_FRAME_WIDTH: begin
                        r_eff_w <= eff_size(i_cfg_data[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_eff_h <= eff_size(i_cfg_data[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Arithmetic datapath: multiply-accumulate, then two serial divisions unless w is zero
    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;

        unique case (r_state)
            S_IDLE: begin
                if (n_emit) begin
                    r_cur_col <= n_col_cur;
                    r_cur_row <= n_row_cur;
                    r_last    <= (SIZE_W'(n_col_cur) == r_eff_w - 1'b1)
                                 && (SIZE_W'(n_row_cur) == r_eff_h - 1'b1);
                    r_step    <= '0;
                    r_acc_u   <= ACC_W'(signed'(r_coef[2]));
                    r_acc_v   <= ACC_W'(signed'(r_coef[5]));
                    r_acc_w   <= ACC_W'(signed'(r_coef[8]));
                    r_axis    <= 1'b0;
                    r_outside <= 1'b0;
                end
            end
            S_MUL: begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    3'd1, 3'd2: r_acc_u <= r_acc_u + ACC_W'(r_prod);
                    3'd3, 3'd4: r_acc_v <= r_acc_v + ACC_W'(r_prod);
                    3'd5, 3'd6: r_acc_w <= r_acc_w + ACC_W'(r_prod);
                    default: begin
                    end
                endcase
            end
            S_DPREP: begin
                r_num <= n_num;
                r_den <= n_den;
                if (r_acc_w == '0) begin
                    r_outside <= 1'b1;
                end
            end
            S_DSTART: begin
                r_neg    <= r_num[NUM_W-1] ^ r_den[NUM_W-1];
                r_rem    <= DIV_W'(n_num_mag);
                r_dsh    <= {n_den_mag, {QB{1'b0}}};
                r_quo    <= '0;
                r_bitcnt <= '0;
            end
            S_DITER: begin
                if (n_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh    <= r_dsh >> 1;
                r_quo    <= n_quo;
                r_bitcnt <= r_bitcnt + 1'b1;
                if (r_bitcnt == CNT_W'(QB)) begin
                    if (r_axis) begin
                        r_sy <= n_quo[QB-1:0];
                    end else begin
                        r_sx <= n_quo[QB-1:0];
                    end
                    r_axis <= 1'b1;
                    if (!n_ok) begin
                        r_outside <= 1'b1;
                    end
                end
            end
            S_ADDR, S_READ: begin
            end
            S_DONE: begin
                if (n_finish) begin
                    r_out.pixel_out  <= r_outside ? '0 : r_rd;
                    r_out.out_col    <= 8'(r_cur_col);
                    r_out.out_row    <= 8'(r_cur_row);
                    r_out.outside    <= r_outside;
                    r_out.last_pixel <= r_last;
                end
            end
            default: begin
            end
        endcase
    end

    // Frame store: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_mem[n_pos[ADDR_W-1:0]] <= i_in_data.pixel_in;
        end
        if (r_state == S_READ) begin
            r_rd <= r_mem[n_addr];
        end
    end

    // A result only appears when the sequencer finishes an emit
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the finish step");

    // The divider never runs past its last quotient bit
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DITER) |-> (r_bitcnt <= CNT_W'(QB)))
        else $error("divider step count overran");

    // The frame store read stays inside the current frame
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ((ADDR_W+1)'(n_addr) < r_size))
        else $error("frame store read beyond frame");

    // Leaving the finish step always leaves a result waiting
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_finish |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished emit lost its result");

endmodule
